// ===== src/lru_cache_with_neighbor_query_top_defines.svh =====
// Assertion macros for the LRU cache block.
`ifndef LRU_CACHE_WITH_NEIGHBOR_QUERY_TOP_DEFINES_SVH
`define LRU_CACHE_WITH_NEIGHBOR_QUERY_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define LRUQ_ASSERT_IMP(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("lruq assertion failed");
`define LRUQ_ASSERT_NEXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("lruq assertion failed");
`else
`define LRUQ_ASSERT_IMP(lbl, pre, post)
`define LRUQ_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

// ===== src/lruq_pkg.sv =====
`timescale 1ns / 1ps
package lruq_pkg;
	localparam int ENTRIES = 1024;
	localparam int IDXW = $clog2(ENTRIES);
	localparam int CNTW = IDXW + 1;
	localparam int KEYW = 38;
	localparam logic [KEYW-1:0] KEY_LEN_WEIGHT = 38'd10000000000;

	localparam logic OP_ACCESS = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	typedef struct packed {
		logic opcode;
		logic [33:0] key_digits;
		logic [3:0] key_length;
		logic signed [31:0] operand;
	} req_t;

	typedef struct packed {
		logic signed [31:0] result_value;
		logic invalid;
	} rsp_t;

	typedef struct packed {
		logic valid;
		logic [KEYW-1:0] key;
	} kent_t;
endpackage

// ===== src/lru_cache_with_neighbor_query_top.sv =====
`timescale 1ns / 1ps
`include "lru_cache_with_neighbor_query_top_defines.svh"
// LRU key/value cache with neighbor query. Issue a word with start while busy
// is low; its result shows on rsp with done high for exactly one cycle, and
// the receiver cannot stall it. Entries, their values and the older/newer
// links of the recency list live in single-port-read synchronous memories.
// Each item begins with a linear scan of the key memory, one entry per cycle,
// which stops at the first hit; a miss scans all ENTRIES slots. List updates
// or a neighbor read follow the scan. After reset the block runs a clearing
// pass over all ENTRIES slots of the key memory with busy high; capacity
// writes are taken at any time (cfg_ready is always high) but should only be
// made while the block is idle.
module lru_cache_with_neighbor_query_top
	import lruq_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  req_t        req,
	output logic        done,
	output rsp_t        rsp,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [10:0] cfg_data
);
	typedef enum logic [3:0] {
		ST_CLR, ST_IDLE, ST_SCAN, ST_RDO, ST_RDOW, ST_UNL, ST_AP1, ST_AP2, ST_QRD, ST_QRDW
	} state_t;

	state_t state_q;
	logic [10:0] capacity_q;
	logic [IDXW-1:0] clr_q, oldest_q, newest_q, s_q, o_q, n_q, f_q, tgt_q, free_q;
	logic [CNTW-1:0] count_q, scan_q;
	logic [IDXW-1:0] addr_s1;
	logic chk_s1, free_found_q, evict_q, kv_q;
	logic [KEYW-1:0] key_q;
	logic opcode_q;
	logic signed [31:0] operand_q, val_q;

	// memories
	kent_t mem_key [ENTRIES];
	logic [31:0] mem_val [ENTRIES];
	logic [IDXW-1:0] mem_old [ENTRIES];
	logic [IDXW-1:0] mem_new [ENTRIES];

	logic [IDXW-1:0] rd_addr;
	kent_t rd_key;
	logic [31:0] rd_val;
	logic [IDXW-1:0] rd_old, rd_new;

	logic kw_en, vw_en, ow_en, nw_en;
	logic [IDXW-1:0] kw_addr, vw_addr, ow_addr, nw_addr, ow_data, nw_data;
	kent_t kw_data;
	logic [31:0] vw_data;

	always_ff @(posedge clk) begin
		if (kw_en) mem_key[kw_addr] <= kw_data;
		rd_key <= mem_key[rd_addr];
	end
	always_ff @(posedge clk) begin
		if (vw_en) mem_val[vw_addr] <= vw_data;
		rd_val <= mem_val[rd_addr];
	end
	always_ff @(posedge clk) begin
		if (ow_en) mem_old[ow_addr] <= ow_data;
		rd_old <= mem_old[rd_addr];
	end
	always_ff @(posedge clk) begin
		if (nw_en) mem_new[nw_addr] <= nw_data;
		rd_new <= mem_new[rd_addr];
	end

	// read address by state
	always_comb begin
		case (state_q)
			ST_SCAN: rd_addr = scan_q[IDXW-1:0];
			ST_RDO:  rd_addr = oldest_q;
			ST_QRD:  rd_addr = tgt_q;
			default: rd_addr = s_q;
		endcase
	end

	// write ports by state
	always_comb begin
		kw_en = 1'b0; kw_addr = s_q; kw_data = '{valid: 1'b1, key: key_q};
		vw_en = 1'b0; vw_addr = f_q; vw_data = val_q;
		ow_en = 1'b0; ow_addr = n_q; ow_data = o_q;
		nw_en = 1'b0; nw_addr = o_q; nw_data = n_q;
		case (state_q)
			ST_CLR: begin
				kw_en = 1'b1;
				kw_addr = clr_q;
				kw_data = '{valid: 1'b0, key: '0};
			end
			ST_UNL: begin
				nw_en = (s_q != oldest_q);
				ow_en = (s_q != newest_q);
				kw_en = evict_q;
				kw_data = '{valid: 1'b0, key: key_q};
			end
			ST_AP1: begin
				ow_en = 1'b1;
				ow_addr = f_q;
				if (count_q == '0) begin
					ow_data = f_q;
				end else begin
					ow_data = newest_q;
					nw_en = 1'b1;
					nw_addr = newest_q;
					nw_data = f_q;
				end
				kw_en = kv_q;
				kw_addr = f_q;
				vw_en = kv_q;
			end
			ST_AP2: begin
				nw_en = 1'b1;
				nw_addr = f_q;
				nw_data = f_q;
			end
			default: begin
			end
		endcase
	end

	// scan compare on the word read last cycle
	logic hit, last, cand_free;
	logic full;
	assign hit = chk_s1 && rd_key.valid && (rd_key.key == key_q);
	assign last = chk_s1 && (addr_s1 == IDXW'(ENTRIES - 1));
	assign cand_free = chk_s1 && !rd_key.valid;
	assign full = (32'(count_q) >= 32'(capacity_q)) || (32'(count_q) >= 32'(ENTRIES));

	assign busy = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			capacity_q <= 11'd1024;
			clr_q <= '0;
			oldest_q <= '0;
			newest_q <= '0;
			count_q <= '0;
			scan_q <= '0;
			chk_s1 <= 1'b0;
			free_found_q <= 1'b0;
			done <= 1'b0;
			rsp <= '0;
			addr_s1 <= '0;
			s_q <= '0;
			o_q <= '0;
			n_q <= '0;
			f_q <= '0;
			tgt_q <= '0;
			free_q <= '0;
			evict_q <= 1'b0;
			kv_q <= 1'b0;
			key_q <= '0;
			opcode_q <= 1'b0;
			operand_q <= '0;
			val_q <= '0;
		end else begin
			done <= 1'b0;
			if (cfg_valid) capacity_q <= cfg_data;
			case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == IDXW'(ENTRIES - 1)) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (start) begin
						opcode_q <= req.opcode;
						operand_q <= req.operand;
						// length weight by shift-and-add of the constant
						key_q <= {4'b0, req.key_digits}
							+ ({KEYW{req.key_length[0]}} & KEY_LEN_WEIGHT)
							+ ({KEYW{req.key_length[1]}} & (KEY_LEN_WEIGHT << 1))
							+ ({KEYW{req.key_length[2]}} & (KEY_LEN_WEIGHT << 2))
							+ ({KEYW{req.key_length[3]}} & (KEY_LEN_WEIGHT << 3));
						scan_q <= '0;
						chk_s1 <= 1'b0;
						free_found_q <= 1'b0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					chk_s1 <= (scan_q != CNTW'(ENTRIES));
					addr_s1 <= scan_q[IDXW-1:0];
					if (scan_q != CNTW'(ENTRIES)) scan_q <= scan_q + 1'b1;
					if (cand_free && !free_found_q) begin
						free_found_q <= 1'b1;
						free_q <= addr_s1;
					end
					if (hit) begin
						s_q <= addr_s1;
						f_q <= addr_s1;
						o_q <= rd_old;
						n_q <= rd_new;
						if (opcode_q == OP_ACCESS) begin
							rsp <= '{result_value: rd_val, invalid: 1'b0};
							val_q <= rd_val;
							if (addr_s1 != newest_q) begin
								evict_q <= 1'b0;
								kv_q <= 1'b0;
								state_q <= ST_UNL;
							end else begin
								done <= 1'b1;
								state_q <= ST_IDLE;
							end
						end else if (operand_q < 0 && addr_s1 == oldest_q) begin
							rsp <= '{result_value: '0, invalid: 1'b1};
							done <= 1'b1;
							state_q <= ST_IDLE;
						end else if (operand_q > 0 && addr_s1 == newest_q) begin
							rsp <= '{result_value: '0, invalid: 1'b1};
							done <= 1'b1;
							state_q <= ST_IDLE;
						end else if (operand_q != 0) begin
							tgt_q <= (operand_q < 0) ? rd_old : rd_new;
							state_q <= ST_QRD;
						end else begin
							rsp <= '{result_value: rd_val, invalid: 1'b0};
							done <= 1'b1;
							state_q <= ST_IDLE;
						end
					end else if (last) begin
						if (opcode_q == OP_QUERY) begin
							rsp <= '{result_value: '0, invalid: 1'b1};
							done <= 1'b1;
							state_q <= ST_IDLE;
						end else begin
							val_q <= operand_q;
							rsp <= '{result_value: operand_q, invalid: 1'b0};
							kv_q <= 1'b1;
							if (full) begin
								if (count_q != '0) begin
									state_q <= ST_RDO;
								end else begin
									done <= 1'b1;
									state_q <= ST_IDLE;
								end
							end else begin
								// room left: a free slot exists
								f_q <= free_found_q ? free_q : addr_s1;
								state_q <= ST_AP1;
							end
						end
					end
				end
				ST_RDO: begin
					state_q <= ST_RDOW;
				end
				ST_RDOW: begin
					s_q <= oldest_q;
					o_q <= rd_old;
					n_q <= rd_new;
					evict_q <= 1'b1;
					state_q <= ST_UNL;
				end
				ST_UNL: begin
					if (s_q == oldest_q) oldest_q <= n_q;
					if (s_q == newest_q) newest_q <= o_q;
					count_q <= count_q - 1'b1;
					// lowest free slot once the victim is gone
					if (evict_q) f_q <= (free_found_q && free_q < s_q) ? free_q : s_q;
					state_q <= ST_AP1;
				end
				ST_AP1: begin
					if (count_q == '0) oldest_q <= f_q;
					state_q <= ST_AP2;
				end
				ST_AP2: begin
					newest_q <= f_q;
					count_q <= count_q + 1'b1;
					done <= 1'b1;
					state_q <= ST_IDLE;
				end
				ST_QRD: begin
					state_q <= ST_QRDW;
				end
				ST_QRDW: begin
					rsp <= '{result_value: rd_val, invalid: 1'b0};
					done <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`LRUQ_ASSERT_NEXT(a_start_busy, start && !busy, busy)
	`LRUQ_ASSERT_IMP(a_invalid_zero, done && rsp.invalid, rsp.result_value == 0)
	`LRUQ_ASSERT_IMP(a_count_bound, 1'b1, 32'(count_q) <= 32'(ENTRIES))
	`LRUQ_ASSERT_IMP(a_done_idle, done, !busy)
endmodule
